// File: src/gchp_pkg.sv
// ----------------------------------------------------------------------------
// gchp_pkg
// Shared types and constants for the grid convex hull prefilter.
// ----------------------------------------------------------------------------
package gchp_pkg;

    localparam int COORD_W = 16;
    localparam int MAX_GS  = 32;
    localparam int GS_W    = $clog2(MAX_GS + 1);
    localparam int CELL_W  = 5;
    localparam int Q_W     = GS_W;
    localparam int BIT_W   = $clog2(Q_W);
    localparam int PROD_W  = COORD_W + GS_W;
    localparam int NUM_W   = PROD_W + 1;
    localparam int SQ_W    = $clog2((MAX_GS + 1) * (MAX_GS + 1) + 1);

    typedef struct packed {
        logic             load_en;
        logic             rb_en;
        logic             flt_start;
        logic             sqrt_step;
        logic             pt_rd;
        logic             pt_mul;
        logic             div_init;
        logic             div_step;
        logic [BIT_W-1:0] div_bit;
        logic             pt_upd;
        logic             result_set;
        logic             out_load;
    } cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic last_pt;
        logic out_busy;
    } stat_t;

endpackage

// File: src/grid_convex_hull_prefilter.sv
// ----------------------------------------------------------------------------
// grid_convex_hull_prefilter
// Loads points, bins them into a sqrt(n)-sided grid and marks points in the
// extreme cells of each column and row as hull candidates.
// ----------------------------------------------------------------------------
//  channel | valid / stall        | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | mode, x_coord, y_coord, last, point_index
//  out     | out_valid / out_stall| out_x, out_y, cell_col, cell_row, kept,
//          |                      | bad_index
//
//  Load beat: accepted only while idle. Readback beat: passes through the registered
//  store read, plus any wait for the output register.
//  A load with last runs the filter: a grid-side search, then for each stored
//  point: store read, multiply, divider init, 6-step cell divider, update.
//  Reset is asynchronous; no clearing pass is needed.
//  in_stall is high whenever the sequencer is not idle; out_stall holds the
//  result in the output register.
module grid_convex_hull_prefilter
#(
    parameter int MAX_POINTS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [15:0] x_coord,
    input  logic [15:0] y_coord,
    input  logic        last,
    input  logic [9:0]  point_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_x,
    output logic [15:0] out_y,
    output logic [4:0]  cell_col,
    output logic [4:0]  cell_row,
    output logic        kept,
    output logic        bad_index
);

    gchp_pkg::cmd_t  cmd;
    gchp_pkg::stat_t st;

    gchp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .last     (last),
        .st       (st),
        .cmd      (cmd)
    );

    gchp_dp #(.MAX_POINTS(MAX_POINTS)) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .point_index (point_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_x       (out_x),
        .out_y       (out_y),
        .cell_col    (cell_col),
        .cell_row    (cell_row),
        .kept        (kept),
        .bad_index   (bad_index)
    );

endmodule

// File: src/gchp_ctrl.sv
// ----------------------------------------------------------------------------
// gchp_ctrl
// Sequencer: accepts beats, steps the grid-side search, the per-point binning
// pass and the readback.
// ----------------------------------------------------------------------------
module gchp_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           mode,
    input  logic           last,
    input  gchp_pkg::stat_t st,
    output gchp_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQRT,
        S_PT_RD,
        S_PT_MUL,
        S_PT_INIT,
        S_PT_DIV,
        S_PT_UPD,
        S_RB_PUT
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [gchp_pkg::BIT_W-1:0]   bit_reg;
    logic [gchp_pkg::BIT_W-1:0]   bit_next;
    logic                         accept;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.div_bit = bit_reg;
        state_next = state_reg;
        bit_next   = bit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode)
                    begin
                        cmd.rb_en  = 1'b1;
                        state_next = S_RB_PUT;
                    end
                    else
                    begin
                        cmd.load_en = 1'b1;
                        if (last)
                        begin
                            cmd.flt_start = 1'b1;
                            state_next    = S_SQRT;
                        end
                    end
                end
            end
            S_SQRT:
            begin
                if (st.sqrt_done)
                    state_next = S_PT_RD;
                else
                    cmd.sqrt_step = 1'b1;
            end
            S_PT_RD:
            begin
                cmd.pt_rd  = 1'b1;
                state_next = S_PT_MUL;
            end
            S_PT_MUL:
            begin
                cmd.pt_mul = 1'b1;
                state_next = S_PT_INIT;
            end
            S_PT_INIT:
            begin
                cmd.div_init = 1'b1;
                bit_next     = gchp_pkg::BIT_W'(gchp_pkg::Q_W - 1);
                state_next   = S_PT_DIV;
            end
            S_PT_DIV:
            begin
                cmd.div_step = 1'b1;
                if (bit_reg == '0)
                    state_next = S_PT_UPD;
                else
                    bit_next = bit_reg - 1'b1;
            end
            S_PT_UPD:
            begin
                cmd.pt_upd = 1'b1;
                if (st.last_pt)
                begin
                    cmd.result_set = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                    state_next = S_PT_RD;
            end
            S_RB_PUT:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

// File: src/gchp_dp.sv
// ----------------------------------------------------------------------------
// gchp_dp
// Datapath: point stores, bounding box, grid-side search, cell divider,
// column/row extremes and the output register.
// ----------------------------------------------------------------------------
module gchp_dp
#(
    parameter int MAX_POINTS = 1024
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  gchp_pkg::cmd_t                   cmd,
    output gchp_pkg::stat_t                  st,
    input  logic [gchp_pkg::COORD_W-1:0]     x_coord,
    input  logic [gchp_pkg::COORD_W-1:0]     y_coord,
    input  logic [9:0]                       point_index,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [gchp_pkg::COORD_W-1:0]     out_x,
    output logic [gchp_pkg::COORD_W-1:0]     out_y,
    output logic [gchp_pkg::CELL_W-1:0]      cell_col,
    output logic [gchp_pkg::CELL_W-1:0]      cell_row,
    output logic                             kept,
    output logic                             bad_index
);

    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int CW     = gchp_pkg::COORD_W;
    localparam int LW     = gchp_pkg::CELL_W;

    // point stores and per-point cells
    logic [CW-1:0]     x_mem [MAX_POINTS];
    logic [CW-1:0]     y_mem [MAX_POINTS];
    logic [2*LW-1:0]   cell_mem [MAX_POINTS];
    logic [CW-1:0]     rd_x_reg;
    logic [CW-1:0]     rd_y_reg;
    logic [2*LW-1:0]   rd_cell_reg;

    logic [CNT_W-1:0]  cnt_reg;
    logic [CW-1:0]     min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic              ready_reg;
    logic [gchp_pkg::GS_W-1:0] g_reg;
    logic [gchp_pkg::SQ_W-1:0] sq_reg;
    logic [ADDR_W-1:0] pt_idx_reg;
    logic              rb_bad_reg;

    logic [gchp_pkg::PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic              zero_x_reg, zero_y_reg;
    logic [gchp_pkg::NUM_W-1:0]  rem_x_reg, rem_y_reg;
    logic [gchp_pkg::Q_W-1:0]    q_x_reg, q_y_reg;

    logic [gchp_pkg::MAX_GS-1:0] col_has_reg, row_has_reg;
    logic [LW-1:0]     col_lo_reg [gchp_pkg::MAX_GS];
    logic [LW-1:0]     col_hi_reg [gchp_pkg::MAX_GS];
    logic [LW-1:0]     row_lo_reg [gchp_pkg::MAX_GS];
    logic [LW-1:0]     row_hi_reg [gchp_pkg::MAX_GS];

    logic              out_valid_reg;
    logic [CW-1:0]     out_x_reg, out_y_reg;
    logic [LW-1:0]     out_col_reg, out_row_reg;
    logic              out_kept_reg, out_bad_reg;

    // combinational
    logic [CNT_W-1:0]  base_cnt;
    logic [CW-1:0]     base_min_x, base_max_x, base_min_y, base_max_y;
    logic              store;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [31:0]       idx32;
    logic [CW-1:0]     d_x, d_y, range_x, range_y;
    logic              zero_x, zero_y;
    logic [gchp_pkg::NUM_W-1:0] div_x, div_y;
    logic [LW-1:0]     cx, cy;
    logic [LW-1:0]     rc, rr;
    logic              kept_w;

    assign idx32      = 32'(point_index);
    assign base_cnt   = ready_reg ? '0 : cnt_reg;
    assign base_min_x = ready_reg ? {CW{1'b1}} : min_x_reg;
    assign base_min_y = ready_reg ? {CW{1'b1}} : min_y_reg;
    assign base_max_x = ready_reg ? '0 : max_x_reg;
    assign base_max_y = ready_reg ? '0 : max_y_reg;
    assign store      = (32'(base_cnt) < 32'(MAX_POINTS));
    assign wr_addr    = base_cnt[ADDR_W-1:0];
    assign rd_addr    = cmd.rb_en ? idx32[ADDR_W-1:0] : pt_idx_reg;

    assign range_x = max_x_reg - min_x_reg;
    assign range_y = max_y_reg - min_y_reg;
    assign d_x     = rd_x_reg - min_x_reg;
    assign d_y     = rd_y_reg - min_y_reg;
    // points on the low edge or a flat axis sit in cell 0
    assign zero_x  = (rd_x_reg <= min_x_reg) || (max_x_reg <= min_x_reg);
    assign zero_y  = (rd_y_reg <= min_y_reg) || (max_y_reg <= min_y_reg);
    assign div_x   = gchp_pkg::NUM_W'(range_x) << cmd.div_bit;
    assign div_y   = gchp_pkg::NUM_W'(range_y) << cmd.div_bit;
    // quotient is ceil(d*G/range) >= 1 whenever the axis is not forced to 0
    assign cx      = zero_x_reg ? '0 : LW'(q_x_reg - gchp_pkg::Q_W'(1));
    assign cy      = zero_y_reg ? '0 : LW'(q_y_reg - gchp_pkg::Q_W'(1));

    assign rc      = rd_cell_reg[2*LW-1:LW];
    assign rr      = rd_cell_reg[LW-1:0];
    assign kept_w  = (col_has_reg[rc] && ((rr == col_lo_reg[rc]) || (rr == col_hi_reg[rc])))
                  || (row_has_reg[rr] && ((rc == row_lo_reg[rr]) || (rc == row_hi_reg[rr])));

    assign st.sqrt_done = (32'(sq_reg) > 32'(cnt_reg))
                       || (g_reg == gchp_pkg::GS_W'(gchp_pkg::MAX_GS));
    assign st.last_pt   = ((32'(pt_idx_reg) + 32'd1) == 32'(cnt_reg));
    assign st.out_busy  = out_valid_reg && out_stall;

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.load_en && store)
        begin
            x_mem[wr_addr] <= x_coord;
            y_mem[wr_addr] <= y_coord;
        end
        if (cmd.pt_upd)
            cell_mem[pt_idx_reg] <= {cx, cy};
        if (cmd.rb_en || cmd.pt_rd)
        begin
            rd_x_reg    <= x_mem[rd_addr];
            rd_y_reg    <= y_mem[rd_addr];
            rd_cell_reg <= cell_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            min_x_reg     <= {CW{1'b1}};
            min_y_reg     <= {CW{1'b1}};
            max_x_reg     <= '0;
            max_y_reg     <= '0;
            ready_reg     <= 1'b0;
            g_reg         <= '0;
            sq_reg        <= '0;
            pt_idx_reg    <= '0;
            col_has_reg   <= '0;
            row_has_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_en)
            begin
                ready_reg <= 1'b0;
                if (store)
                begin
                    cnt_reg   <= base_cnt + 1'b1;
                    min_x_reg <= (x_coord < base_min_x) ? x_coord : base_min_x;
                    max_x_reg <= (x_coord > base_max_x) ? x_coord : base_max_x;
                    min_y_reg <= (y_coord < base_min_y) ? y_coord : base_min_y;
                    max_y_reg <= (y_coord > base_max_y) ? y_coord : base_max_y;
                end
                else
                begin
                    cnt_reg   <= base_cnt;
                    min_x_reg <= base_min_x;
                    max_x_reg <= base_max_x;
                    min_y_reg <= base_min_y;
                    max_y_reg <= base_max_y;
                end
            end
            if (cmd.result_set)
                ready_reg <= 1'b1;

            if (cmd.flt_start)
            begin
                g_reg       <= '0;
                sq_reg      <= gchp_pkg::SQ_W'(1);
                pt_idx_reg  <= '0;
                col_has_reg <= '0;
                row_has_reg <= '0;
            end
            // sq tracks (g+1)^2
            if (cmd.sqrt_step)
            begin
                g_reg  <= g_reg + 1'b1;
                sq_reg <= sq_reg + (gchp_pkg::SQ_W'(g_reg) << 1) + gchp_pkg::SQ_W'(3);
            end
            if (cmd.pt_upd)
            begin
                pt_idx_reg      <= pt_idx_reg + 1'b1;
                col_has_reg[cx] <= 1'b1;
                row_has_reg[cy] <= 1'b1;
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.rb_en)
            rb_bad_reg <= !ready_reg || (idx32 >= 32'(cnt_reg)) || (idx32 >= 32'(MAX_POINTS));
        if (cmd.pt_mul)
        begin
            prod_x_reg <= gchp_pkg::PROD_W'(d_x) * gchp_pkg::PROD_W'(g_reg);
            prod_y_reg <= gchp_pkg::PROD_W'(d_y) * gchp_pkg::PROD_W'(g_reg);
            zero_x_reg <= zero_x;
            zero_y_reg <= zero_y;
        end
        if (cmd.div_init)
        begin
            rem_x_reg <= gchp_pkg::NUM_W'(prod_x_reg) + gchp_pkg::NUM_W'(range_x)
                       - gchp_pkg::NUM_W'(1);
            rem_y_reg <= gchp_pkg::NUM_W'(prod_y_reg) + gchp_pkg::NUM_W'(range_y)
                       - gchp_pkg::NUM_W'(1);
            q_x_reg   <= '0;
            q_y_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            if (rem_x_reg >= div_x)
            begin
                rem_x_reg            <= rem_x_reg - div_x;
                q_x_reg[cmd.div_bit] <= 1'b1;
            end
            if (rem_y_reg >= div_y)
            begin
                rem_y_reg            <= rem_y_reg - div_y;
                q_y_reg[cmd.div_bit] <= 1'b1;
            end
        end
        if (cmd.pt_upd)
        begin
            if (!col_has_reg[cx])
            begin
                col_lo_reg[cx] <= cy;
                col_hi_reg[cx] <= cy;
            end
            else
            begin
                if (cy < col_lo_reg[cx])
                    col_lo_reg[cx] <= cy;
                if (cy > col_hi_reg[cx])
                    col_hi_reg[cx] <= cy;
            end
            if (!row_has_reg[cy])
            begin
                row_lo_reg[cy] <= cx;
                row_hi_reg[cy] <= cx;
            end
            else
            begin
                if (cx < row_lo_reg[cy])
                    row_lo_reg[cy] <= cx;
                if (cx > row_hi_reg[cy])
                    row_hi_reg[cy] <= cx;
            end
        end
        if (cmd.out_load)
        begin
            out_bad_reg  <= rb_bad_reg;
            out_x_reg    <= rb_bad_reg ? '0 : rd_x_reg;
            out_y_reg    <= rb_bad_reg ? '0 : rd_y_reg;
            out_col_reg  <= rb_bad_reg ? '0 : rc;
            out_row_reg  <= rb_bad_reg ? '0 : rr;
            out_kept_reg <= rb_bad_reg ? 1'b0 : kept_w;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign cell_col  = out_col_reg;
    assign cell_row  = out_row_reg;
    assign kept      = out_kept_reg;
    assign bad_index = out_bad_reg;

endmodule

// File: src/gchp_check.sv
// ----------------------------------------------------------------------------
// gchp_check
// Port-level checks for the grid convex hull prefilter.
// ----------------------------------------------------------------------------
module gchp_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        mode,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] out_x,
    input logic [15:0] out_y,
    input logic [4:0]  cell_col,
    input logic [4:0]  cell_row,
    input logic        kept,
    input logic        bad_index
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(cell_col) && $stable(cell_row) && $stable(kept) && $stable(bad_index))
        else $error("stalled result changed");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_index |-> (out_x == 16'd0) && (out_y == 16'd0)
            && (cell_col == 5'd0) && (cell_row == 5'd0) && !kept)
        else $error("bad readback carries data");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !mode |=> !$rose(out_valid))
        else $error("load produced a result");

    a_rb_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode |=> in_stall)
        else $error("readback did not hold input");

endmodule

bind grid_convex_hull_prefilter gchp_check u_gchp_check
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .cell_col  (cell_col),
    .cell_row  (cell_row),
    .kept      (kept),
    .bad_index (bad_index)
);
